@@ rtl/dqra_pkg.sv @@
// Package for the deque with remove-at block: field widths, command and
// status codes, and the control/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package dqra_pkg;

    // Field widths of the stream payloads
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam int IN_DATA_W  = 40;  // 39 used bits, padded to whole bytes
    localparam int OUT_DATA_W = 72;  // 71 used bits, padded to whole bytes

    localparam int DEF_CAPACITY = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic                latch;       // capture input transfer
        logic                push_front;
        logic                push_back;
        logic                pop_front;
        logic                dec_count;   // pop back, or end of a remove
        logic                shift_start;
        logic                shift_step;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                rd_ends;     // read front and back entries
        logic                load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             pos_ok;
        logic             need_shift;
        logic             last_read;
        logic             out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/deque_with_remove_at.sv @@
// Top level of the bounded deque with remove-at: controller plus datapath,
// stream packing and checks. Depends on dqra_pkg, dqra_ctrl, dqra_dp.
//
// Usage:
//   Commands enter on the s_axis channel, one transfer per command; every
//   command gives exactly one result transfer on the m_axis channel, in order.
//   Commands: push front, push back, pop front, pop back, remove at position.
//   A result carries status, element count, front and back value.
//   Push and pop commands pass the decode, end-read and result states before
//   the next input transfer; m_axis_tvalid rises once the result register loads.
//   Remove at position moves each element behind the removed one, one per
//   cycle through store read port A, then lets the final write land before
//   the end reads and the result load.
//   s_axis_tready is high only while no command is being worked on.
//   The result sits in an output register: the next command is taken while
//   it waits; if the receiver still stalls when the next result is ready,
//   the controller holds until the register frees.
//   Reset (synchronous, active low) empties the queue and drops any result;
//   the store itself is not cleared and needs no clearing pass.
`default_nettype none

module deque_with_remove_at
    import dqra_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [2:0] cmd, [34:3] value, [38:35] position, [39] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [1:0] status, [6:2] count, [38:7] front_value, [70:39] back_value, [71] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    logic [STATUS_W-1:0] w_status;
    logic [COUNT_W-1:0]  w_count;
    logic [VALUE_W-1:0]  w_front;
    logic [VALUE_W-1:0]  w_back;

    dqra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dqra_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_cmd    (s_axis_tdata[2:0]),
        .i_in_value  (s_axis_tdata[34:3]),
        .i_in_pos    (s_axis_tdata[38:35]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_count     (w_count),
        .o_front     (w_front),
        .o_back      (w_back)
    );

    // Result packing
    assign m_axis_tdata = {1'b0, w_back, w_front, w_count, w_status};

    // One command in flight: no transfer right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a command is in flight");

    // A dropped push reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL)
            |-> (m_axis_tdata[6:2] == COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    // Empty queue reports zero ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[6:2] == '0) && (CAPACITY < 32)
            |-> (m_axis_tdata[70:7] == '0))
        else $error("empty queue result with nonzero end values");

endmodule

`default_nettype wire

@@ rtl/dqra_ctrl.sv @@
// Controller for the deque with remove-at block: sequences command decode,
// the element shift of remove-at, the end reads and the result load.
// Depends on dqra_pkg.
`default_nettype none

module dqra_ctrl
    import dqra_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_DRAIN = 6'b001000,
        S_READ  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_READ;
                unique case (i_sts.cmd)
                    CMD_PUSH_FRONT: begin
                        if (i_sts.full) o_cmd.status = ST_FULL;
                        else o_cmd.push_front = 1'b1;
                    end
                    CMD_PUSH_BACK: begin
                        if (i_sts.full) o_cmd.status = ST_FULL;
                        else o_cmd.push_back = 1'b1;
                    end
                    CMD_POP_FRONT: begin
                        if (i_sts.empty) o_cmd.status = ST_IGNORED;
                        else o_cmd.pop_front = 1'b1;
                    end
                    CMD_POP_BACK: begin
                        if (i_sts.empty) o_cmd.status = ST_IGNORED;
                        else o_cmd.dec_count = 1'b1;
                    end
                    CMD_REMOVE_AT: begin
                        if (!i_sts.pos_ok) begin
                            o_cmd.status = ST_IGNORED;
                        end else if (i_sts.need_shift) begin
                            o_cmd.shift_start = 1'b1;
                            n_state           = S_SHIFT;
                        end else begin
                            // last element removed: nothing to move
                            o_cmd.dec_count = 1'b1;
                        end
                    end
                    default: o_cmd.status = ST_IGNORED;
                endcase
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_sts.last_read) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                // final write lands this cycle
                o_cmd.dec_count = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.rd_ends = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dqra_dp.sv @@
// Datapath for the deque with remove-at block: circular element store,
// front index and count, shift pipeline and the result register.
// Depends on dqra_pkg.
`default_nettype none

module dqra_dp
    import dqra_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [CMD_W-1:0]    i_in_cmd,
    input  wire logic [VALUE_W-1:0]  i_in_value,
    input  wire logic [POS_W-1:0]    i_in_pos,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_count,
    output logic [VALUE_W-1:0]       o_front,
    output logic [VALUE_W-1:0]       o_back
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Offset from the front to a store slot; both terms below CAPACITY
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] front,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= (AW+1)'(CAPACITY)) sum = sum - (AW+1)'(CAPACITY);
        return sum[AW-1:0];
    endfunction

    logic [CMD_W-1:0]    r_cmd;
    logic [VALUE_W-1:0]  r_value;
    logic [POS_W-1:0]    r_pos;
    logic [AW-1:0]       r_front;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_sh_idx;
    logic [AW-1:0]       r_wr_off;
    logic                r_wr_vld;
    logic [STATUS_W-1:0] r_status;
    logic [VALUE_W-1:0]  r_mem [CAPACITY];
    logic [VALUE_W-1:0]  r_rd_a;
    logic [VALUE_W-1:0]  r_rd_b;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_count;
    logic [VALUE_W-1:0]  r_out_front;
    logic [VALUE_W-1:0]  r_out_back;

    logic [AW-1:0]       n_front_dec;
    logic                n_we;
    logic [AW-1:0]       n_waddr;
    logic [VALUE_W-1:0]  n_wdata;
    logic [AW-1:0]       n_raddr_a;
    logic [AW-1:0]       n_raddr_b;
    logic [PW-1:0]       n_pos_ext;
    logic [PW-1:0]       n_cnt_ext;

    assign n_front_dec = (r_front == '0) ? AW'(CAPACITY - 1) : r_front - AW'(1);
    assign n_pos_ext   = PW'(r_pos);
    assign n_cnt_ext   = PW'(r_count);

    // Status back to the controller
    assign o_sts.cmd        = r_cmd;
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count >= CW'(CAPACITY));
    assign o_sts.pos_ok     = (n_pos_ext < n_cnt_ext);
    assign o_sts.need_shift = ((n_pos_ext + PW'(1)) < n_cnt_ext);
    assign o_sts.last_read  = ((CW'(r_sh_idx) + CW'(1)) == r_count);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Store write port: pushes and shift writes never coincide
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_front;
        n_wdata = r_value;
        if (i_cmd.push_front) begin
            n_we    = 1'b1;
            n_waddr = n_front_dec;
        end else if (i_cmd.push_back) begin
            n_we    = 1'b1;
            n_waddr = f_slot(r_front, AW'(r_count));
        end else if (r_wr_vld) begin
            n_we    = 1'b1;
            n_waddr = f_slot(r_front, r_wr_off);
            n_wdata = r_rd_a;
        end
    end

    // Read addresses: shift source on port A, else the two ends
    assign n_raddr_a = i_cmd.shift_step ? f_slot(r_front, r_sh_idx) : r_front;
    assign n_raddr_b = f_slot(r_front, AW'(r_count - CW'(1)));

    // Element store
    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        if (i_cmd.shift_step || i_cmd.rd_ends) r_rd_a <= r_mem[n_raddr_a];
        if (i_cmd.rd_ends) r_rd_b <= r_mem[n_raddr_b];
    end

    // Input capture and shift bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd   <= i_in_cmd;
            r_value <= i_in_value;
            r_pos   <= i_in_pos;
        end
        if (i_cmd.set_status) r_status <= i_cmd.status;
        if (i_cmd.shift_start) begin
            r_sh_idx <= AW'(n_pos_ext + PW'(1));
        end else if (i_cmd.shift_step) begin
            r_sh_idx <= r_sh_idx + AW'(1);
            r_wr_off <= r_sh_idx - AW'(1);
        end
    end

    // Front index, count and pending shift write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= i_cmd.shift_step;
            if (i_cmd.push_front) begin
                r_front <= n_front_dec;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.push_back) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_front) begin
                r_front <= f_slot(r_front, AW'(1));
                r_count <= r_count - CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
            r_out_front  <= (r_count == '0) ? '0 : r_rd_a;
            r_out_back   <= (r_count == '0) ? '0 : r_rd_b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_front     = r_out_front;
    assign o_back      = r_out_back;

endmodule

`default_nettype wire
